// ===== rtl/core/rocr_pkg.sv =====
// rocr_pkg: shared constants for the rate of change ratio block
`timescale 1ns / 1ps

package rocr_pkg;

   // default sizing of the sample ring and the sample word
   localparam int MAX_LAG_DEF      = 256;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // result format, signed Q16.16
   localparam int RATIO_W  = 32;
   localparam int Q_SHIFT  = 16;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;
   localparam logic [RATIO_W-1:0] RATIO_MIN = 32'h8000_0000;

   // series position counter, saturating
   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1_FFFF;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LAG_W      = 8;
   localparam int LEAD_W     = 16;
   localparam logic REG_LAG  = 1'b0;
   localparam logic REG_LEAD = 1'b1;
   localparam logic [LAG_W-1:0]  LAG_RESET  = 8'd10;
   localparam logic [LEAD_W-1:0] LEAD_RESET = 16'd0;

   // result beat sideband: bit 0 ratio_valid, bit 1 ratio_saturated
   localparam int RSP_USER_W = 2;

endpackage

// ===== rtl/core/rate_of_change_ratio.sv =====
// rate_of_change_ratio: relative change of a sample stream against a lagged sample
`timescale 1ns / 1ps
//
// channel   role    payload
// -------   -----   ----------------------------------------------------------
// req_*     in      tdata: price (SAMPLE_WIDTH, signed Q16.16); tuser: series_start
// rsp_*     out     tdata: ratio (32, signed Q16.16); tuser: ratio_valid, ratio_saturated
// csr_*     config  APB-style, lag at 0x0, lead_discard at 0x4
//
// one shared restoring divider produces one quotient bit per cycle; the dividend is
// |x - r| << 16; a valid item with a nonzero reference steps through S_PREP, S_ABS,
// S_DIV and S_FIN before the next accept, an invalid item goes straight to S_FIN and
// a zero-reference item steps through S_PREP and then S_FIN
// reset is synchronous and clears the sequencer, pointer, count and anchor; the
// sample ring is not cleared, an entry only feeds a valid result after it was written
// req_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so a new beat is taken while rsp waits on rsp_tready; a result
// that finds the output register still full holds the sequencer until it drains

module rate_of_change_ratio #(
   parameter int MAX_LAG      = rocr_pkg::MAX_LAG_DEF,
   parameter int SAMPLE_WIDTH = rocr_pkg::SAMPLE_WIDTH_DEF,
   parameter int REQ_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_TDATA_W-1:0]             req_tdata,   // [SAMPLE_WIDTH-1:0] price
   input  logic                               req_tuser,   // [0] series_start
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rocr_pkg::RATIO_W-1:0]       rsp_tdata,   // [31:0] ratio
   output logic [rocr_pkg::RSP_USER_W-1:0]    rsp_tuser,   // [0] ratio_valid, [1] ratio_saturated
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rocr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rocr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rocr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int PTR_W  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   // dividend |x - r| needs SW + 1 bits, then the Q16.16 shift
   localparam int DW     = SW + 1 + rocr_pkg::Q_SHIFT;
   localparam int CNT_W  = $clog2(DW + 1);
   localparam int THR_W  = rocr_pkg::COUNT_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(MAX_LAG - 1);
   localparam logic [PTR_W:0]   RING_DEPTH = (PTR_W + 1)'(MAX_LAG);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_ABS,
      S_DIV,
      S_FIN
   } state_type;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   logic [rocr_pkg::LAG_W-1:0]   lag_ff;
   logic [rocr_pkg::LEAD_W-1:0]  lead_ff;

   state_type                    state_ff, state_in;
   logic [rocr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [SW-1:0]                anchor_ff, anchor_in;
   logic                         taken_ff, taken_in;

   logic [SW-1:0]                x_ff, x_in;
   logic [SW-1:0]                anc_ref_ff, anc_ref_in;
   logic                         use_anc_ff, use_anc_in;
   logic                         valid_res_ff, valid_res_in;
   logic                         zres_ff, zres_in;
   logic [SW:0]                  diff_ff, diff_in;
   logic [SW-1:0]                dvs_ff, dvs_in;
   logic                         neg_ff, neg_in;
   logic [DW-1:0]                quo_ff, quo_in;
   logic [SW-1:0]                rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rocr_pkg::RATIO_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_vflag_ff, rsp_vflag_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   // sample ring
   logic [SW-1:0]                ring [MAX_LAG];
   logic [SW-1:0]                ring_q_ff;

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // word decode on paddr[2], byte lanes ignored
   always_comb begin
      case (csr_paddr[2])
         rocr_pkg::REG_LAG:  csr_prdata = rocr_pkg::CSR_DATA_W'(lag_ff);
         rocr_pkg::REG_LEAD: csr_prdata = rocr_pkg::CSR_DATA_W'(lead_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff  <= rocr_pkg::LAG_RESET;
         lead_ff <= rocr_pkg::LEAD_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == rocr_pkg::REG_LAG) begin
            lag_ff <= csr_pwdata[rocr_pkg::LAG_W-1:0];
         end else begin
            lead_ff <= csr_pwdata[rocr_pkg::LEAD_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // accept-cycle decisions
   // ------------------------------------------------------------------
   logic                         accept;
   logic                         start;
   logic [SW-1:0]                x_now;
   logic [PTR_W-1:0]             eff_lag;
   logic [PTR_W-1:0]             wp_eff;
   logic [rocr_pkg::COUNT_W-1:0] pos;
   logic                         taken_eff;
   logic [THR_W-1:0]             thresh;
   logic                         valid_now;
   logic [PTR_W:0]               rd_sum;
   logic [PTR_W-1:0]             rd_idx;
   logic [PTR_W-1:0]             wp_next;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser;
   assign x_now      = req_tdata[SW-1:0];

   // a lag that reaches past the ring acts as the deepest entry
   assign eff_lag   = (32'(lag_ff) >= 32'(MAX_LAG)) ? LAST_PTR : PTR_W'(lag_ff);

   // series_start clears pointer, count and anchor before this sample counts
   assign wp_eff    = start ? '0 : wp_ff;
   assign pos       = start ? '0 : count_ff;
   assign taken_eff = start ? 1'b0 : taken_ff;

   assign thresh    = THR_W'(lead_ff) + THR_W'(eff_lag);
   assign valid_now = (THR_W'(pos) >= thresh);

   // ring slot eff_lag samples back, wrapped on a ring of MAX_LAG
   assign rd_sum  = {1'b0, wp_eff} + ((wp_eff < eff_lag) ? RING_DEPTH : '0)
                    - {1'b0, eff_lag};
   assign rd_idx  = rd_sum[PTR_W-1:0];
   assign wp_next = (wp_eff == LAST_PTR) ? '0 : wp_eff + 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         ring[wp_eff] <= x_now;
         ring_q_ff    <= ring[rd_idx];
      end
   end

   // ------------------------------------------------------------------
   // datapath helpers
   // ------------------------------------------------------------------
   logic [SW-1:0]  ref_val;
   logic [SW:0]    abs_diff;
   logic [SW:0]    trial;
   logic           trial_ge;
   logic           sat_pos;
   logic           sat_neg;
   logic           out_free;

   assign ref_val  = use_anc_ff ? anc_ref_ff : ring_q_ff;
   assign abs_diff = diff_ff[SW] ? (SW + 1)'(0) - diff_ff : diff_ff;
   // shared unit: one compare and subtract per quotient bit
   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});
   assign sat_pos  = (quo_ff[DW-1:31] != '0);
   assign sat_neg  = (quo_ff[DW-1:32] != '0) || (quo_ff[31] && (quo_ff[30:0] != '0));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ------------------------------------------------------------------
   // sequencer next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      anchor_in    = anchor_ff;
      taken_in     = taken_ff;
      x_in         = x_ff;
      anc_ref_in   = anc_ref_ff;
      use_anc_in   = use_anc_ff;
      valid_res_in = valid_res_ff;
      zres_in      = zres_ff;
      diff_in      = diff_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_vflag_in = rsp_vflag_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in         = x_now;
               valid_res_in = valid_now;
               use_anc_in   = (eff_lag == '0);
               anc_ref_in   = taken_eff ? anchor_ff : x_now;
               taken_in     = taken_eff;
               if (valid_now && (eff_lag == '0) && !taken_eff) begin
                  anchor_in = x_now;
                  taken_in  = 1'b1;
               end
               wp_in    = wp_next;
               count_in = (pos == rocr_pkg::COUNT_MAX) ? pos : pos + 1'b1;
               if (valid_now) begin
                  zres_in  = 1'b0;
                  state_in = S_PREP;
               end else begin
                  zres_in  = 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         S_PREP: begin
            diff_in = {x_ff[SW-1], x_ff} - {ref_val[SW-1], ref_val};
            dvs_in  = ref_val[SW-1] ? SW'(0) - ref_val : ref_val;
            neg_in  = ((SW + 1)'({x_ff[SW-1], x_ff} - {ref_val[SW-1], ref_val}) >> SW) != '0
                      ? !ref_val[SW-1] : ref_val[SW-1];
            if (ref_val == '0) begin
               zres_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            quo_in   = {abs_diff, rocr_pkg::Q_SHIFT'(0)};
            rem_in   = '0;
            cnt_in   = CNT_W'(DW);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = trial_ge ? SW'(trial - {1'b0, dvs_ff}) : trial[SW-1:0];
            quo_in = {quo_ff[DW-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vflag_in = valid_res_ff;
               if (zres_ff) begin
                  rsp_data_in = '0;
                  rsp_sat_in  = 1'b0;
               end else if (neg_ff) begin
                  rsp_sat_in  = sat_neg;
                  rsp_data_in = sat_neg ? rocr_pkg::RATIO_MIN
                                        : rocr_pkg::RATIO_W'(0) - quo_ff[31:0];
               end else begin
                  rsp_sat_in  = sat_pos;
                  rsp_data_in = sat_pos ? rocr_pkg::RATIO_MAX : quo_ff[31:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wp_ff        <= '0;
         anchor_ff    <= '0;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         anchor_ff    <= anchor_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      anc_ref_ff   <= anc_ref_in;
      use_anc_ff   <= use_anc_in;
      valid_res_ff <= valid_res_in;
      zres_ff      <= zres_in;
      diff_ff      <= diff_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_vflag_ff <= rsp_vflag_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_vflag_ff};

endmodule

// ===== rtl/core/rocr_checker.sv =====
// rocr_checker: port-level assertions for the rate of change ratio block
`timescale 1ns / 1ps

module rocr_checker #(
   parameter int REQ_TDATA_W = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [REQ_TDATA_W-1:0]             req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [rocr_pkg::RATIO_W-1:0]       rsp_tdata,
   input  logic [rocr_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   // a waiting input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("req beat changed while waiting");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // the sequencer is busy after a sample is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after accept");

   // an invalid result, inside the discarded lead or the lag, gives a plain zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("invalid result not zero");

   // a clipped quotient sits at one of the range ends
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] &&
         ((rsp_tdata == rocr_pkg::RATIO_MAX) || (rsp_tdata == rocr_pkg::RATIO_MIN)))
      else $error("saturated ratio off the range ends");

endmodule

bind rate_of_change_ratio rocr_checker #(
   .REQ_TDATA_W (REQ_TDATA_W)
) u_rocr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/rate_of_change_ratio_tb.sv =====
// rate_of_change_ratio_tb: self-checking testbench for the rate of change ratio block
`timescale 1ns / 1ps

module rate_of_change_ratio_tb;

   localparam int CLK_HALF     = 2;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYC   = 8;     // pause before a register write
   localparam int TAIL_CYC     = 64;    // longer than one divide
   localparam int MAX_SHOWN    = 10;
   localparam int RING_DEPTH   = 256;

   // one result beat as the block should present it
   typedef struct packed {
      logic [rocr_pkg::RATIO_W-1:0] ratio;
      logic                         valid;
      logic                         saturated;
   } ratio_beat_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [31:0]                         req_tdata   = '0;   // [31:0] price
   logic                                req_tuser   = 1'b0; // [0] series_start
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [rocr_pkg::RATIO_W-1:0]        rsp_tdata;          // [31:0] ratio
   logic [rocr_pkg::RSP_USER_W-1:0]     rsp_tuser;          // [0] ratio_valid, [1] ratio_saturated
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [rocr_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [rocr_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [rocr_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   rate_of_change_ratio dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // shadow of the block: sample history, series position, anchor, registers
   // ---------------------------------------------------------------------------
   logic [31:0]                  price_hist [RING_DEPTH];
   logic [7:0]                   hist_wr_ptr = '0;
   logic [rocr_pkg::COUNT_W-1:0] series_pos  = '0;
   longint                       anchor_px   = 0;
   logic                         anchor_set  = 1'b0;
   logic [rocr_pkg::LAG_W-1:0]   shadow_lag  = rocr_pkg::LAG_RESET;
   logic [rocr_pkg::LEAD_W-1:0]  shadow_lead = rocr_pkg::LEAD_RESET;

   ratio_beat_type pending_ratios[$];   // oldest first
   ratio_beat_type oldest_ratio;
   int             error_count   = 0;
   int             cycle_count   = 0;
   int             send_idle_pct = 0;
   int             stall_pct     = 0;

   // next result for one accepted sample; advances the shadow state
   function automatic ratio_beat_type predict_ratio(logic [31:0] price, logic start);
      ratio_beat_type     beat;
      longint             x;
      longint             r;
      longint             diff;
      longint unsigned    num;
      longint unsigned    den;
      longint unsigned    quo;
      logic               neg;
      logic [7:0]         rd_idx;
      int                 pos;
      beat = '0;
      x    = longint'($signed(price));
      if (start) begin
         // a new series forgets position, pointer and anchor
         series_pos  = '0;
         hist_wr_ptr = '0;
         anchor_px   = 0;
         anchor_set  = 1'b0;
      end
      pos = int'(series_pos);
      // lag fits in 8 bits, so it never reaches the ring depth
      if (pos >= int'(shadow_lead) + int'(shadow_lag)) begin
         beat.valid = 1'b1;
         if (shadow_lag == '0) begin
            if (!anchor_set) begin
               anchor_px  = x;
               anchor_set = 1'b1;
            end
            r = anchor_px;
         end else begin
            rd_idx = hist_wr_ptr - shadow_lag;
            r      = longint'($signed(price_hist[rd_idx]));
         end
         // zero reference leaves the ratio at zero
         if (r != 0) begin
            diff = x - r;
            neg  = (diff < 0) != (r < 0);
            num  = (diff < 0) ? longint'(-diff) : diff;
            den  = (r < 0) ? longint'(-r) : r;
            quo  = (num << rocr_pkg::Q_SHIFT) / den;
            if (neg) begin
               if (quo > 64'h8000_0000) begin
                  quo            = 64'h8000_0000;
                  beat.saturated = 1'b1;
               end
               beat.ratio = -quo[31:0];
            end else begin
               if (quo > 64'h7FFF_FFFF) begin
                  quo            = 64'h7FFF_FFFF;
                  beat.saturated = 1'b1;
               end
               beat.ratio = quo[31:0];
            end
         end
      end
      price_hist[hist_wr_ptr] = price;
      hist_wr_ptr             = hist_wr_ptr + 8'd1;
      if (series_pos != rocr_pkg::COUNT_MAX) series_pos = series_pos + 1'b1;
      return beat;
   endfunction

   task automatic note_error(input string what, input logic [31:0] want,
                             input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   // ---------------------------------------------------------------------------
   // result side: random backpressure and the per-beat check
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ratios.size() == 0) begin
            note_error("unexpected result beat", '0, rsp_tdata);
         end else begin
            oldest_ratio = pending_ratios.pop_front();
            if (rsp_tdata !== oldest_ratio.ratio)
               note_error("ratio", oldest_ratio.ratio, rsp_tdata);
            if (rsp_tuser[0] !== oldest_ratio.valid)
               note_error("ratio_valid", 32'(oldest_ratio.valid), 32'(rsp_tuser[0]));
            if (rsp_tuser[1] !== oldest_ratio.saturated)
               note_error("ratio_saturated", 32'(oldest_ratio.saturated),
                          32'(rsp_tuser[1]));
         end
      end
   end

   // watchdog: far above the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_ratios.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // bus tasks
   // ---------------------------------------------------------------------------

   // one input beat; valid stays up afterwards until the next call or a drain
   task automatic send_sample(input logic [31:0] price, input logic start);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      pending_ratios.push_back(predict_ratio(price, start));
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_drained(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_ratios.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register lands on this edge
      if (reg_idx == rocr_pkg::REG_LAG) shadow_lag = value[rocr_pkg::LAG_W-1:0];
      else shadow_lead = value[rocr_pkg::LEAD_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_csr(input logic reg_idx);
      logic [31:0] want;
      want = (reg_idx == rocr_pkg::REG_LAG) ? 32'(shadow_lag) : 32'(shadow_lead);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) note_error("register readback", want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input int lag_val, input int lead_val);
      write_csr(rocr_pkg::REG_LAG, 32'(lag_val));
      write_csr(rocr_pkg::REG_LEAD, 32'(lead_val));
   endtask

   // a price walk in four of ten draws, with full-range words, zeros, extremes and bounded values mixed in
   function automatic logic [31:0] next_price(logic [31:0] prev);
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: return '0;
         3: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         4, 5: return 32'($urandom_range(13_107_200)) - 32'd6_553_600;
         default: return prev + ((32'($urandom_range(2000)) - 32'd1000) << 8);
      endcase
   endfunction

   // series of random length, each opened with series_start; a few stray
   // restarts and a few series that simply run on
   task automatic random_series(input int n_items, input int min_len, input int max_len);
      int          left;
      logic        start;
      logic [31:0] price;
      left  = 0;
      price = $urandom;
      repeat (n_items) begin
         start = 1'b0;
         if (left == 0) begin
            left  = $urandom_range(max_len, min_len);
            start = ($urandom_range(9) != 0);
         end else if ($urandom_range(99) == 0) begin
            start = 1'b1;
         end
         left--;
         price = next_price(price);
         send_sample(price, start);
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall);
      send_idle_pct = send_pct;
      stall_pct     = stall;
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset values, then both registers at their top values, then both at zero
   task automatic test_register_access();
      check_csr(rocr_pkg::REG_LAG);
      check_csr(rocr_pkg::REG_LEAD);
      set_config(255, 65535);
      check_csr(rocr_pkg::REG_LAG);
      check_csr(rocr_pkg::REG_LEAD);
      set_config(0, 0);
      check_csr(rocr_pkg::REG_LAG);
      check_csr(rocr_pkg::REG_LEAD);
   endtask

   // saturation both ways, zero reference, anchor rules, lead discard
   task automatic test_directed_cases();
      set_idling(0, 0);
      set_config(1, 0);
      send_sample(32'h0000_0001, 1'b1);   // first sample is never valid at lag 1
      send_sample(32'h7FFF_FFFF, 1'b0);   // huge rise clips high
      send_sample(32'h8000_0000, 1'b0);   // full-scale drop
      send_sample(32'h0000_0001, 1'b0);   // against the most negative reference
      send_sample(32'h0000_0000, 1'b0);   // drop to zero
      send_sample(32'h0000_0005, 1'b0);   // zero reference
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);   // negative over negative clips high
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h8000_0000, 1'b0);   // clips low
      send_sample(32'h0000_0007, 1'b1);   // restart mid-stream
      send_sample(32'h0000_0007, 1'b0);
      wait_drained(SETTLE_CYC);
      // lag 0: ratio against the first valid sample of the series
      set_config(0, 0);
      send_sample(32'h0000_0000, 1'b1);   // zero anchor keeps the series at zero
      send_sample(32'h0000_0064, 1'b0);
      send_sample(32'hFFFF_FFFD, 1'b1);   // negative anchor
      send_sample(32'h0000_0003, 1'b0);
      wait_drained(SETTLE_CYC);
      set_config(0, 2);
      send_sample(32'h0000_0004, 1'b1);   // inside the discarded lead
      send_sample(32'h0000_0008, 1'b0);
      send_sample(32'h0000_0002, 1'b0);   // becomes the anchor
      send_sample(32'h0000_0006, 1'b0);
      wait_drained(SETTLE_CYC);
      // anchor survives a lag change within the series
      write_csr(rocr_pkg::REG_LAG, 32'd3);
      send_sample(32'h0000_000A, 1'b0);
      wait_drained(SETTLE_CYC);
      write_csr(rocr_pkg::REG_LAG, 32'd0);
      send_sample(32'h0000_0001, 1'b0);
      wait_drained(SETTLE_CYC);
   endtask

   // short lags over a price walk, first with no gaps then with backpressure
   task automatic test_short_lag();
      set_config(1, 0);
      set_idling(0, 0);
      random_series(200, 10, 60);
      wait_drained(SETTLE_CYC);
      set_config($urandom_range(20, 2), $urandom_range(5, 0));
      set_idling(0, 57);
      random_series(250, 10, 60);
      wait_drained(SETTLE_CYC);
   endtask

   // anchor mode with and without a discarded lead
   task automatic test_anchor_mode();
      set_config(0, 2);
      set_idling(57, 0);
      random_series(200, 5, 40);
      wait_drained(SETTLE_CYC);
      set_config(0, 0);
      set_idling(29, 29);
      random_series(150, 5, 40);
      wait_drained(SETTLE_CYC);
   endtask

   // deepest lag: long series so the ring wraps
   task automatic test_long_lag();
      set_config(255, 0);
      set_idling(29, 29);
      random_series(350, 300, 400);
      wait_drained(SETTLE_CYC);
   endtask

   // largest lead: every result stays invalid
   task automatic test_long_lead();
      set_config(5, 65535);
      set_idling(57, 0);
      random_series(30, 10, 30);
      wait_drained(SETTLE_CYC);
   endtask

   // random settings; the sender stops after each run to let everything drain
   task automatic test_random_mix();
      set_config($urandom_range(40, 1), $urandom_range(50, 0));
      set_idling(0, 0);
      random_series(85, 20, 120);
      wait_drained(0);
      random_series(85, 20, 120);
      wait_drained(SETTLE_CYC);
      set_config($urandom_range(255, 100), $urandom_range(50, 0));
      set_idling(29, 29);
      random_series(200, 150, 300);
      wait_drained(SETTLE_CYC);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_cases();
      test_short_lag();
      test_anchor_mode();
      test_long_lag();
      test_long_lead();
      test_random_mix();
      // catch any stray beat that would trail the last expected one
      wait_drained(TAIL_CYC);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
